### rtl/cfqc_pkg.sv
package cfqc_pkg;

   // frame layout
   localparam logic [7:0] FRAME_MAGIC = 8'h5A;
   localparam logic [7:0] CHECK_BASE  = 8'hFF;
   localparam logic [7:0] STATUS_OK   = 8'h00;
   localparam int         FRAME_BYTES = 8;
   localparam int         ENTRY_W     = 40;
   localparam int         LEN_W       = 4;

   // largest command identifier that a response may carry, plus one
   localparam logic [7:0] CMD_LIMIT   = 8'd8;

   // response status codes
   localparam logic [7:0] STATUS_MAX  = 8'd2;
   localparam logic [1:0] STAGE_UNKNOWN = 2'd3;

   // error flag bits
   localparam int ERR_MAGIC    = 0;
   localparam int ERR_UNEXP    = 1;
   localparam int ERR_BAD_CMD  = 2;
   localparam int ERR_CHECKSUM = 3;
   localparam int ERR_STATUS   = 4;

   // result tuser bits
   localparam int U_ACCEPTED   = 0;
   localparam int U_TX_VALID   = 1;
   localparam int U_RESP_VALID = 2;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_SEND   = 3'd1,
      OP_DROP   = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_RXBYTE = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic             accepted;
      logic [7:0]       tx_byte;
      logic             tx_valid;
      logic             last;
      logic [LEN_W-1:0] queue_length;
      logic             resp_valid;
      logic [4:0]       error_flags;
      logic [1:0]       stage_status;
      logic [31:0]      resp_data;
   } rsp_type;

endpackage

### rtl/cfqc_ram.sv
module cfqc_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/command_frame_queue_and_checker.sv
// channel | direction | handshake                 | tuser                 | tdata
// req_    | in        | req_tvalid / req_tready   | opcode                | command, payload, rx_byte
// rsp_    | out       | rsp_tvalid / rsp_tready   | accepted, tx, resp vld| tx_byte ... resp_data
//
// push, drop, clear, unused opcodes and response bytes are handled as they are accepted;
// a send goes through the accept, the queue ram read of the head entry (ST_FETCH),
// then eight frame beats out of the single result register.
// reset (synchronous) empties the queue, drops the expectation and restarts
// response collection; the queue ram itself is not cleared.
// while a result waits with rsp_tready low, no new input beat is taken.
module command_frame_queue_and_checker
   import cfqc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // command[7:0], payload[39:8], rx_byte[47:40]
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // tx_byte[7:0], queue_length[11:8], error_flags[16:12],
                                    // stage_status[18:17], resp_data[50:19], zero[55:51]
   output logic [2:0]  rsp_tuser,   // accepted[0], tx_valid[1], resp_valid[2]
   output logic        rsp_tlast
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       expected_ff, expected_in;
   logic             expect_valid_ff, expect_valid_in;
   logic [2:0]       rx_pos_ff, rx_pos_in;
   logic [7:0]       rx_sum_ff, rx_sum_in;
   logic [55:0]      rx_fields_ff, rx_fields_in;
   logic [2:0]       byte_idx_ff, byte_idx_in;
   logic [7:0]       tx_sum_ff, tx_sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic               accept;
   logic               out_free;
   logic               rsp_load;
   logic [7:0]         frame_byte;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [7:0]         in_command;
   logic [31:0]        in_payload;
   logic [7:0]         in_rx_byte;
   logic [7:0]         rx_cmd;
   logic [7:0]         rx_status;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign in_command = req_tdata[7:0];
   assign in_payload = req_tdata[39:8];
   assign in_rx_byte = req_tdata[47:40];
   assign rx_cmd     = rx_fields_ff[15:8];
   assign rx_status  = rx_fields_ff[55:48];

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // queue storage
   cfqc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data ({in_command, in_payload}),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // frame byte selected by the beat index
   always_comb begin
      case (byte_idx_ff)
         3'd0:    frame_byte = FRAME_MAGIC;
         3'd1:    frame_byte = ram_rd_data[39:32];
         3'd2:    frame_byte = ram_rd_data[7:0];
         3'd3:    frame_byte = ram_rd_data[15:8];
         3'd4:    frame_byte = ram_rd_data[23:16];
         3'd5:    frame_byte = ram_rd_data[31:24];
         3'd6:    frame_byte = STATUS_OK;
         default: frame_byte = CHECK_BASE - tx_sum_ff;
      endcase
   end

   // sequencer: next state, queue updates and result contents
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      expected_in     = expected_ff;
      expect_valid_in = expect_valid_ff;
      rx_pos_in       = rx_pos_ff;
      rx_sum_in       = rx_sum_ff;
      rx_fields_in    = rx_fields_ff;
      byte_idx_in     = byte_idx_ff;
      tx_sum_in       = tx_sum_ff;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      rsp_load        = 1'b0;
      rsp_in          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  OP_PUSH: begin
                     rsp_load     = 1'b1;
                     rsp_in.last  = 1'b1;
                     if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                        ram_wr_en       = 1'b1;
                        tail_in         = wrap_next(tail_ff);
                        count_in        = count_ff + 1'b1;
                        rsp_in.accepted = 1'b1;
                     end
                  end
                  OP_SEND: begin
                     if (count_ff == '0) begin
                        rsp_load    = 1'b1;
                        rsp_in.last = 1'b1;
                     end else begin
                        ram_rd_en = 1'b1;
                        head_in   = wrap_next(head_ff);
                        count_in  = count_ff - 1'b1;
                        state_in  = ST_FETCH;
                     end
                  end
                  OP_DROP: begin
                     rsp_load    = 1'b1;
                     rsp_in.last = 1'b1;
                     if (count_ff != '0) begin
                        head_in         = wrap_next(head_ff);
                        count_in        = count_ff - 1'b1;
                        rsp_in.accepted = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     // head moves past every entry, which lands on the tail
                     head_in         = tail_ff;
                     count_in        = '0;
                     rsp_load        = 1'b1;
                     rsp_in.last     = 1'b1;
                     rsp_in.accepted = 1'b1;
                  end
                  OP_RXBYTE: begin
                     if (rx_pos_ff != 3'd7) begin
                        rx_fields_in[{rx_pos_ff, 3'b000} +: 8] = in_rx_byte;
                        rx_sum_in = rx_sum_ff + in_rx_byte;
                        rx_pos_in = rx_pos_ff + 1'b1;
                     end else begin
                        // eighth byte: check and decode the collected frame
                        rsp_load          = 1'b1;
                        rsp_in.last       = 1'b1;
                        rsp_in.accepted   = 1'b1;
                        rsp_in.resp_valid = 1'b1;
                        rsp_in.resp_data  = rx_fields_ff[47:16];
                        rsp_in.error_flags[ERR_MAGIC] = rx_fields_ff[7:0] != FRAME_MAGIC;
                        rsp_in.error_flags[ERR_UNEXP] =
                           expect_valid_ff && (rx_cmd != expected_ff);
                        rsp_in.error_flags[ERR_BAD_CMD] = rx_cmd >= CMD_LIMIT;
                        rsp_in.error_flags[ERR_CHECKSUM] =
                           in_rx_byte != (CHECK_BASE - rx_sum_ff);
                        if (rx_status <= STATUS_MAX) begin
                           rsp_in.stage_status = rx_status[1:0];
                        end else begin
                           rsp_in.stage_status = STAGE_UNKNOWN;
                           rsp_in.error_flags[ERR_STATUS] = 1'b1;
                        end
                        rx_pos_in    = '0;
                        rx_sum_in    = '0;
                        rx_fields_in = '0;
                     end
                  end
                  default: begin
                     rsp_load    = 1'b1;
                     rsp_in.last = 1'b1;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            // head entry now on the ram output
            expected_in     = ram_rd_data[39:32];
            expect_valid_in = 1'b1;
            byte_idx_in     = '0;
            tx_sum_in       = '0;
            state_in        = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_in.accepted = 1'b1;
               rsp_in.tx_valid = 1'b1;
               rsp_in.tx_byte  = frame_byte;
               rsp_in.last     = byte_idx_ff == 3'(FRAME_BYTES - 1);
               tx_sum_in       = tx_sum_ff + frame_byte;
               byte_idx_in     = byte_idx_ff + 1'b1;
               if (byte_idx_ff == 3'(FRAME_BYTES - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.queue_length = LEN_W'(count_in);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         head_ff         <= '0;
         tail_ff         <= '0;
         count_ff        <= '0;
         expected_ff     <= '0;
         expect_valid_ff <= 1'b0;
         rx_pos_ff       <= '0;
         rx_sum_ff       <= '0;
         rx_fields_ff    <= '0;
         byte_idx_ff     <= '0;
         tx_sum_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
         expected_ff     <= expected_in;
         expect_valid_ff <= expect_valid_in;
         rx_pos_ff       <= rx_pos_in;
         rx_sum_ff       <= rx_sum_in;
         rx_fields_ff    <= rx_fields_in;
         byte_idx_ff     <= byte_idx_in;
         tx_sum_ff       <= tx_sum_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tuser  = {rsp_ff.resp_valid, rsp_ff.tx_valid, rsp_ff.accepted};
   assign rsp_tdata  = {5'b0, rsp_ff.resp_data, rsp_ff.stage_status, rsp_ff.error_flags,
                        rsp_ff.queue_length, rsp_ff.tx_byte};

endmodule

### rtl/cfqc_checker.sv
module cfqc_checker
   import cfqc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result beat holds its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // no result is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input is held off while the result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   // only frame bytes come in runs longer than one beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[U_TX_VALID] && rsp_tuser[U_ACCEPTED])
      else $error("non-final beat that is not a frame byte");

   // a checked response is a single final beat, never a frame byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[U_RESP_VALID] |-> rsp_tlast && !rsp_tuser[U_TX_VALID])
      else $error("response result mixed with frame byte");

endmodule

bind command_frame_queue_and_checker cfqc_checker u_cfqc_checker (.*);

### dv/tb_command_frame_queue_and_checker.sv
`timescale 1ns / 1ps

module tb_command_frame_queue_and_checker;
   import cfqc_pkg::*;

   localparam int DEPTH        = 8;
   localparam int RANDOM_ITEMS = 450;
   localparam int HOLDOFF_LEN  = 400;
   localparam int DRAIN_CYCLES = 32;
   localparam int STALL_LIMIT  = 4000;

   // opcodes the block does not decode
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [7:0]  cmd;
      logic [31:0] value;
   } entry_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // command[7:0], payload[39:8], rx_byte[47:40]
   logic [2:0]  req_tuser  = '0;   // opcode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // tx_byte, queue_length, error_flags, stage_status, resp_data
   logic [2:0]  rsp_tuser;         // accepted, tx_valid, resp_valid
   logic        rsp_tlast;

   // shadow of the queue and of the response collector
   entry_type   shadow_store [DEPTH];
   int unsigned shadow_head    = 0;
   int unsigned shadow_tail    = 0;
   int unsigned shadow_count   = 0;
   logic [7:0]  armed_cmd      = '0;
   logic        cmd_armed      = 1'b0;
   int unsigned rx_bytes_held  = 0;
   logic [7:0]  rx_check_acc   = '0;
   logic [55:0] rx_frame       = '0;

   rsp_type     due_results [$];
   int          failures      = 0;
   int          items_sent    = 0;
   int          burst_left    = 0;
   bit          steady_sender = 1'b0;

   // receiver stall state
   int          hold_seq      = 0;
   int          hold_seen     = 0;
   int          hold_left     = 0;
   int          pattern_age   = 0;
   logic [31:0] stall_pattern = '1;
   int          quiet_cycles  = 0;

   command_frame_queue_and_checker #(.QUEUE_DEPTH(DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result with the common fields filled in
   function automatic rsp_type plain_result(logic acc, logic lst);
      rsp_type r;
      r = '0;
      r.accepted     = acc;
      r.last         = lst;
      r.queue_length = shadow_count[LEN_W-1:0];
      return r;
   endfunction

   // random byte
   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // advance the shadow state by one accepted beat and queue its results
   function automatic void predict_results(logic [2:0] op, logic [7:0] cmd,
                                           logic [31:0] value, logic [7:0] rxb);
      rsp_type    r;
      entry_type  e;
      logic [7:0] frame [FRAME_BYTES];
      logic [7:0] sum;
      logic [7:0] rcmd;
      logic [7:0] status;
      logic [4:0] flags;
      case (op)
      OP_PUSH: begin
         if (shadow_count < DEPTH) begin
            shadow_store[shadow_tail] = {cmd, value};
            shadow_tail = (shadow_tail + 1) % DEPTH;
            shadow_count++;
            due_results.push_back(plain_result(1'b1, 1'b1));
         end else begin
            due_results.push_back(plain_result(1'b0, 1'b1));
         end
      end
      OP_SEND: begin
         if (shadow_count == 0) begin
            due_results.push_back(plain_result(1'b0, 1'b1));
         end else begin
            e = shadow_store[shadow_head];
            frame[0] = FRAME_MAGIC;
            frame[1] = e.cmd;
            frame[2] = e.value[7:0];
            frame[3] = e.value[15:8];
            frame[4] = e.value[23:16];
            frame[5] = e.value[31:24];
            frame[6] = STATUS_OK;
            sum = '0;
            for (int i = 0; i < FRAME_BYTES - 1; i++) sum += frame[i];
            frame[7] = CHECK_BASE - sum;
            armed_cmd = e.cmd;
            cmd_armed = 1'b1;
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_count--;
            for (int i = 0; i < FRAME_BYTES; i++) begin
               r = plain_result(1'b1, i == FRAME_BYTES - 1);
               r.tx_byte  = frame[i];
               r.tx_valid = 1'b1;
               due_results.push_back(r);
            end
         end
      end
      OP_DROP: begin
         if (shadow_count > 0) begin
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_count--;
            due_results.push_back(plain_result(1'b1, 1'b1));
         end else begin
            due_results.push_back(plain_result(1'b0, 1'b1));
         end
      end
      OP_CLEAR: begin
         shadow_head = (shadow_head + shadow_count) % DEPTH;
         shadow_count = 0;
         due_results.push_back(plain_result(1'b1, 1'b1));
      end
      OP_RXBYTE: begin
         if (rx_bytes_held < FRAME_BYTES - 1) begin
            rx_frame[8*rx_bytes_held +: 8] = rxb;
            rx_check_acc += rxb;
            rx_bytes_held++;
         end else begin
            // eighth byte: check and decode the collected frame
            rcmd   = rx_frame[15:8];
            status = rx_frame[55:48];
            sum    = CHECK_BASE - rx_check_acc;
            flags  = '0;
            flags[ERR_MAGIC]    = rx_frame[7:0] != FRAME_MAGIC;
            flags[ERR_UNEXP]    = cmd_armed && (rcmd != armed_cmd);
            flags[ERR_BAD_CMD]  = rcmd >= CMD_LIMIT;
            flags[ERR_CHECKSUM] = rxb != sum;
            flags[ERR_STATUS]   = status > STATUS_MAX;
            r = plain_result(1'b1, 1'b1);
            r.resp_valid   = 1'b1;
            r.error_flags  = flags;
            r.stage_status = flags[ERR_STATUS] ? STAGE_UNKNOWN : status[1:0];
            r.resp_data    = rx_frame[47:16];
            due_results.push_back(r);
            rx_bytes_held = 0;
            rx_check_acc  = '0;
            rx_frame      = '0;
         end
      end
      default: begin
         due_results.push_back(plain_result(1'b0, 1'b1));
      end
      endcase
   endfunction

   // offer one beat in bursts with random gaps, wait for the handshake
   task automatic send_item(logic [2:0] op, logic [7:0] cmd, logic [31:0] value,
                            logic [7:0] rxb);
      int gap;
      if (burst_left <= 0) begin
         gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {rxb, value, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_results(op, cmd, value, rxb);
      items_sent++;
   endtask

   // eight response bytes with the given header, status and checksum choice
   task automatic send_response_frame(logic [7:0] magic, logic [7:0] cmd,
                                      logic [31:0] value, logic [7:0] status,
                                      bit sum_ok);
      logic [7:0] bytes [FRAME_BYTES];
      logic [7:0] sum;
      bytes[0] = magic;
      bytes[1] = cmd;
      bytes[2] = value[7:0];
      bytes[3] = value[15:8];
      bytes[4] = value[23:16];
      bytes[5] = value[31:24];
      bytes[6] = status;
      sum = '0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) sum += bytes[i];
      bytes[7] = sum_ok ? CHECK_BASE - sum
                        : 8'(CHECK_BASE - sum + 8'($urandom_range(1, 255)));
      for (int i = 0; i < FRAME_BYTES; i++)
         send_item(OP_RXBYTE, rand_byte(), $urandom, bytes[i]);
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         failures++;
      end
   endtask

   // send, drop, clear and undecoded opcodes on an empty queue
   task automatic test_empty_queue();
      send_item(OP_SEND, rand_byte(), $urandom, rand_byte());
      send_item(OP_DROP, rand_byte(), $urandom, rand_byte());
      send_item(OP_CLEAR, rand_byte(), $urandom, rand_byte());
      send_item(OP_SPARE_FIRST, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
      send_item(OP_SPARE_LAST, 8'h00, 32'h0000_0000, 8'h00);
   endtask

   // response before any send: nothing armed, every other error raised
   task automatic test_unarmed_response();
      send_response_frame(8'hA5, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
   endtask

   // fill past full with extreme entries, then send, drop and clear
   task automatic test_fill_and_wrap();
      send_item(OP_PUSH, 8'h00, 32'h0000_0000, 8'hFF);
      send_item(OP_PUSH, 8'hFF, 32'hFFFF_FFFF, 8'h00);
      for (int i = 0; i < DEPTH - 1; i++)
         send_item(OP_PUSH, rand_byte(), $urandom, rand_byte());
      send_item(OP_SEND, rand_byte(), $urandom, rand_byte());
      send_item(OP_DROP, rand_byte(), $urandom, rand_byte());
      send_item(OP_CLEAR, rand_byte(), $urandom, rand_byte());
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_output_holdoff();
      steady_sender = 1'b1;
      hold_seq++;
      for (int i = 0; i < 6; i++)
         send_item(OP_PUSH, 8'($urandom_range(0, 7)), $urandom, rand_byte());
      for (int i = 0; i < 4; i++)
         send_item(OP_SEND, rand_byte(), $urandom, rand_byte());
      send_item(OP_DROP, rand_byte(), $urandom, rand_byte());
      send_item(OP_PUSH, rand_byte(), $urandom, rand_byte());
      send_item(OP_SEND, rand_byte(), $urandom, rand_byte());
      steady_sender = 1'b0;
   endtask

   // mostly well-formed traffic, with partial frames and corrupt fields as noise
   task automatic test_random_traffic(int count);
      int          stop_at;
      int          pick;
      logic [7:0]  magic;
      logic [7:0]  rcmd;
      logic [7:0]  status;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            // finish any partial frame so the next one lines up
            while (rx_bytes_held != 0)
               send_item(OP_RXBYTE, rand_byte(), $urandom, rand_byte());
            magic  = ($urandom_range(0, 9) != 0) ? FRAME_MAGIC : rand_byte();
            rcmd   = ($urandom_range(0, 6) != 0) ?
                     (cmd_armed ? armed_cmd : 8'($urandom_range(0, 7))) : rand_byte();
            status = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 2))
                                                 : 8'($urandom_range(3, 255));
            send_response_frame(magic, rcmd, $urandom, status, $urandom_range(0, 6) != 0);
         end else if (pick < 65) begin
            send_item(OP_PUSH,
                      $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : rand_byte(),
                      $urandom, rand_byte());
         end else if (pick < 80) begin
            send_item(OP_SEND, rand_byte(), $urandom, rand_byte());
         end else if (pick < 88) begin
            send_item(OP_DROP, rand_byte(), $urandom, rand_byte());
         end else if (pick < 92) begin
            send_item(OP_CLEAR, rand_byte(), $urandom, rand_byte());
         end else if (pick < 95) begin
            send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), rand_byte(),
                      $urandom, rand_byte());
         end else begin
            // broken frame: a few stray response bytes
            repeat ($urandom_range(1, FRAME_BYTES - 1))
               send_item(OP_RXBYTE, rand_byte(), $urandom, rand_byte());
         end
      end
   endtask

   // receiver: rotating stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLDOFF_LEN;
      end
      if (pattern_age == 0) begin
         pattern_age = 48;
         case ($urandom_range(0, 3))
         0: stall_pattern = '1;
         1: stall_pattern = $urandom;
         default: stall_pattern = $urandom | $urandom;
         endcase
      end
      pattern_age--;
      stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= stall_pattern[0];
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none actual %h/%h",
                     $time, rsp_tuser, rsp_tdata);
            failures++;
         end else begin
            want = due_results.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(rsp_tuser[U_ACCEPTED]));
            check_field("tx_valid", 32'(want.tx_valid), 32'(rsp_tuser[U_TX_VALID]));
            check_field("resp_valid", 32'(want.resp_valid), 32'(rsp_tuser[U_RESP_VALID]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
            check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_tdata[7:0]));
            check_field("queue_length", 32'(want.queue_length), 32'(rsp_tdata[11:8]));
            check_field("error_flags", 32'(want.error_flags), 32'(rsp_tdata[16:12]));
            check_field("stage_status", 32'(want.stage_status), 32'(rsp_tdata[18:17]));
            check_field("resp_data", want.resp_data, rsp_tdata[50:19]);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, due_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_unarmed_response();
      test_fill_and_wrap();
      test_output_holdoff();
      test_random_traffic(RANDOM_ITEMS);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
rtl/cfqc_pkg.sv
rtl/cfqc_ram.sv
rtl/command_frame_queue_and_checker.sv
rtl/cfqc_checker.sv
dv/tb_command_frame_queue_and_checker.sv
